// File: rtl/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Shared types and codes for the adjacency matrix store.
// ----------------------------------------------------------------------------
package ams_pkg;

   // vertex index and count widths are fixed by the request format
   localparam int unsigned VTX_W = 6;
   localparam int unsigned CNT_W = 7;

   // request kinds
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_LIST  = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // response status codes
   localparam logic STAT_OK    = 1'b0;
   localparam logic STAT_RANGE = 1'b1;

   typedef logic [VTX_W-1:0] vertex_type;

   // one response word
   typedef struct packed {
      logic       status;
      logic       adjacent;
      logic       found;
      vertex_type neighbor;
      logic       last;
   } rsp_type;

   // row memory access command
   typedef struct packed {
      logic       rd_en;
      vertex_type rd_addr;
      logic       wr_en;
      vertex_type wr_addr;
   } mem_cmd_type;

endpackage

// File: rtl/ams_row_mem.sv
// ----------------------------------------------------------------------------
// ams_row_mem
// Adjacency row memory: one read and one write port, registered read data.
// Per-row valid flags make every row read as zero after reset.
// ----------------------------------------------------------------------------
module ams_row_mem #(
   parameter int unsigned ROWS  = 64,
   parameter int unsigned ROW_W = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ams_pkg::mem_cmd_type cmd,
   input  logic [ROW_W-1:0]     wr_data,
   output logic [ROW_W-1:0]     rd_data
);
   import ams_pkg::*;

   localparam int unsigned IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [ROW_W-1:0] mem [ROWS];
   logic [ROWS-1:0]  valid_ff;
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;

   assign rd_idx = cmd.rd_addr[IDX_W-1:0];
   assign wr_idx = cmd.wr_addr[IDX_W-1:0];

   // storage array, read before write on the same row
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   // row valid flags, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   // a row never written reads as empty
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: rtl/ams_ctrl.sv
// ----------------------------------------------------------------------------
// ams_ctrl
// Request sequencer: range check, row read-modify-write for add, row read
// for query, row walk for neighbor listing, and the response register.
// ----------------------------------------------------------------------------
module ams_ctrl #(
   parameter int unsigned ROW_W = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [6:0]            eff_count,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  ams_pkg::vertex_type   req_a,
   input  ams_pkg::vertex_type   req_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ams_pkg::rsp_type      rsp,
   output ams_pkg::mem_cmd_type  mem_cmd,
   output logic [ROW_W-1:0]      mem_wr_data,
   input  logic [ROW_W-1:0]      mem_rd_data
);
   import ams_pkg::*;

   localparam int unsigned IDX_W = (ROW_W > 1) ? $clog2(ROW_W) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROW_A = 3'd1;
   localparam logic [2:0] S_ROW_B = 3'd2;
   localparam logic [2:0] S_RESP  = 3'd3;
   localparam logic [2:0] S_LIST  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   vertex_type       a_ff, a_in;
   vertex_type       b_ff, b_in;
   rsp_type          pend_ff, pend_in;
   logic [ROW_W-1:0] scan_ff, scan_in;
   vertex_type       nbr_ff, nbr_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             out_free;
   logic             a_oor;
   logic             b_oor;
   logic [ROW_W-1:0] count_mask;
   logic [ROW_W-1:0] row_used;
   logic [ROW_W-1:0] bit_a;
   logic [ROW_W-1:0] bit_b;
   logic             scan_last;

   // response word sent with a plain completion
   localparam rsp_type RSP_DONE = '{status: STAT_OK, adjacent: 1'b0, found: 1'b0,
                                    neighbor: '0, last: 1'b1};

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign a_oor     = {1'b0, req_a} >= eff_count;
   assign b_oor     = {1'b0, req_b} >= eff_count;
   assign bit_a     = {{(ROW_W-1){1'b0}}, 1'b1} << a_ff[IDX_W-1:0];
   assign bit_b     = {{(ROW_W-1){1'b0}}, 1'b1} << b_ff[IDX_W-1:0];
   assign row_used  = mem_rd_data & count_mask;
   assign scan_last = ~|scan_ff[ROW_W-1:1];

   // vertices below the count are listed
   always_comb begin
      for (int j = 0; j < ROW_W; j++) begin
         count_mask[j] = 7'(j) < eff_count;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      pend_in      = pend_ff;
      scan_in      = scan_ff;
      nbr_in       = nbr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mem_cmd      = '0;
      mem_wr_data  = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               a_in    = req_a;
               b_in    = req_b;
               if (req_kind == KIND_NONE) begin
                  state_in = S_IDLE;
               end else if (a_oor || (req_kind != KIND_LIST && b_oor)) begin
                  pend_in        = RSP_DONE;
                  pend_in.status = STAT_RANGE;
                  state_in       = S_RESP;
               end else begin
                  mem_cmd.rd_en   = 1'b1;
                  mem_cmd.rd_addr = req_a;
                  state_in        = S_ROW_A;
               end
            end
         end

         S_ROW_A: begin
            case (kind_ff)
               KIND_ADD: begin
                  // set bit b in row a, fetch row b
                  mem_cmd.wr_en   = 1'b1;
                  mem_cmd.wr_addr = a_ff;
                  mem_wr_data     = mem_rd_data | bit_b;
                  mem_cmd.rd_en   = 1'b1;
                  mem_cmd.rd_addr = b_ff;
                  state_in        = S_ROW_B;
               end
               KIND_QUERY: begin
                  pend_in          = RSP_DONE;
                  pend_in.adjacent = mem_rd_data[b_ff[IDX_W-1:0]];
                  state_in         = S_RESP;
               end
               KIND_LIST: begin
                  if (row_used == '0) begin
                     pend_in  = RSP_DONE;
                     state_in = S_RESP;
                  end else begin
                     scan_in  = row_used;
                     nbr_in   = '0;
                     state_in = S_LIST;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_ROW_B: begin
            // set bit a in row b; a self loop rewrites the same value
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = b_ff;
            mem_wr_data     = mem_rd_data | bit_a;
            pend_in         = RSP_DONE;
            state_in        = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_LIST: begin
            // one row position per cycle, stall while a word waits
            if (scan_ff[0]) begin
               if (out_free) begin
                  rsp_in          = RSP_DONE;
                  rsp_in.found    = 1'b1;
                  rsp_in.neighbor = nbr_ff;
                  rsp_in.last     = scan_last;
                  rsp_valid_in    = 1'b1;
                  scan_in         = scan_ff >> 1;
                  nbr_in          = nbr_ff + 6'd1;
                  if (scan_last) begin
                     state_in = S_IDLE;
                  end
               end
            end else begin
               scan_in = scan_ff >> 1;
               nbr_in  = nbr_ff + 6'd1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      pend_ff <= pend_in;
      scan_ff <= scan_in;
      nbr_ff  <= nbr_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: rtl/adjacency_matrix_store.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_store
// Undirected graph kept as a square bit matrix of vertex adjacency; handles
// add edge, adjacency query and ascending neighbor listing.
//
//   channel  dir  handshake            contents
//   req      in   req_tvalid/tready    tuser: kind; tdata: vertex_a, vertex_b
//   rsp      out  rsp_tvalid/tready    tdata: status, adjacent, found,
//                                      neighbor; tlast: last word of request
//   csr      in   csr_we               vertex_count
//
// One request at a time. Out-of-range requests skip the row memory; a query
// reads one row; add edge does two row read-modify-writes through the one read
// port of the row memory. List fetches the row, then walks it one row position
// per cycle while no response word waits, up to and including the highest
// neighbor; a row with no neighbors in range ends after the row fetch.
// Reset clears all rows at once through per-row valid flags; no clear pass.
// A stalled response holds the sequencer; a waiting word does not block
// acceptance of the next request.
// ----------------------------------------------------------------------------
module adjacency_matrix_store #(
   parameter int unsigned MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] vertex_a, [11:6] vertex_b, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] status, [1] adjacent, [2] found,
                                    // [8:3] neighbor, rest zero
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);
   import ams_pkg::*;

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        eff_count;
   mem_cmd_type             mem_cmd;
   logic [MAX_VERTICES-1:0] mem_wr_data;
   logic [MAX_VERTICES-1:0] mem_rd_data;
   rsp_type                 rsp;

   // vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd64;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // counts above the matrix size act as the matrix size
   assign eff_count = (count_ff > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_ff;

   ams_ctrl #(
      .ROW_W (MAX_VERTICES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .eff_count   (eff_count),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_a       (req_tdata[5:0]),
      .req_b       (req_tdata[11:6]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp),
      .mem_cmd     (mem_cmd),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   ams_row_mem #(
      .ROWS  (MAX_VERTICES),
      .ROW_W (MAX_VERTICES)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // response word packing
   assign rsp_tdata = {7'd0, rsp.neighbor, rsp.found, rsp.adjacent, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

// File: test/tb_adjacency_matrix_store.sv
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_store
// Self-checking bench for the adjacency matrix store. Requests for add edge,
// adjacency query and neighbor listing go in on the req stream. A graph
// scoreboard keeps its own copy of the bit matrix and the vertex count,
// predicts every response word and checks each word field by field in order.
// Both streams see random gaps, and one long response hold-off backs the
// block up. The vertex count is rewritten between phases, including 0, 1, 64
// and 127.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_store;
   timeunit 1ns;
   timeprecision 1ps;

   import ams_pkg::*;

   localparam int unsigned NV          = 64;
   localparam int unsigned IDLE_LIMIT  = 3000;
   localparam int unsigned DRAIN_WAIT  = 80;   // a full row walk plus margin
   localparam int unsigned HOLD_OFF    = 150;  // long response stall

   // graph scoreboard: private matrix copy and queue of predicted words
   class graph_scoreboard;
      bit [NV-1:0]  adj_rows [NV];
      int unsigned  vertex_limit;
      rsp_type      expected_words [$];
      int unsigned  errors;
      int unsigned  words_seen;
      int unsigned  requests_seen;
      int unsigned  lists_seen;
      int unsigned  ranges_seen;

      function new();
         foreach (adj_rows[i]) adj_rows[i] = '0;
         vertex_limit  = NV;
         errors        = 0;
         words_seen    = 0;
         requests_seen = 0;
         lists_seen    = 0;
         ranges_seen   = 0;
      endfunction

      // counts above the matrix size act as the full size
      function void set_count(logic [CNT_W-1:0] value);
         vertex_limit = (value > NV) ? NV : value;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      // predict the words caused by one accepted request
      function void note_request(logic [1:0] kind, vertex_type a, vertex_type b);
         rsp_type     w;
         int unsigned i;
         int          hi;
         if (kind == KIND_NONE) return;
         requests_seen++;
         w      = '0;
         w.last = 1'b1;
         if (a >= vertex_limit || (kind != KIND_LIST && b >= vertex_limit)) begin
            w.status = STAT_RANGE;
            ranges_seen++;
            expected_words.push_back(w);
            return;
         end
         w.status = STAT_OK;
         case (kind)
            KIND_ADD: begin
               adj_rows[a][b] = 1'b1;
               adj_rows[b][a] = 1'b1;
               expected_words.push_back(w);
            end
            KIND_QUERY: begin
               w.adjacent = adj_rows[a][b] | adj_rows[b][a];
               expected_words.push_back(w);
            end
            KIND_LIST: begin
               lists_seen++;
               hi = -1;
               for (i = 0; i < vertex_limit; i++)
                  if (adj_rows[a][i] | adj_rows[i][a]) hi = int'(i);
               if (hi < 0) begin
                  expected_words.push_back(w);
               end else begin
                  for (i = 0; int'(i) <= hi; i++) begin
                     if (adj_rows[a][i] | adj_rows[i][a]) begin
                        w.found    = 1'b1;
                        w.neighbor = i[VTX_W-1:0];
                        w.last     = (int'(i) == hi);
                        expected_words.push_back(w);
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare(string field, logic [15:0] exp_val, logic [15:0] act_val);
         if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, field, exp_val, act_val);
            errors++;
         end
      endfunction

      // check one accepted response word against the oldest prediction
      function void check_word(logic [15:0] data, logic tlast);
         rsp_type w;
         words_seen++;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected response word, expected none actual tdata %0h tlast %b",
                     $time, data, tlast);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         compare("status",   16'(w.status),   16'(data[0]));
         compare("adjacent", 16'(w.adjacent), 16'(data[1]));
         compare("found",    16'(w.found),    16'(data[2]));
         compare("neighbor", 16'(w.neighbor), 16'(data[8:3]));
         compare("padding",  16'd0,           16'(data[15:9]));
         compare("last",     16'(w.last),     16'(tlast));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // [5:0] vertex_a, [11:6] vertex_b, rest zero
   logic [1:0]  req_tuser  = '0;    // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [0] status, [1] adjacent, [2] found,
                                    // [8:3] neighbor, rest zero
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [6:0]  csr_wdata  = '0;

   graph_scoreboard sb = new();
   bit              no_idle       = 1'b0;
   bit              pressure_done = 1'b0;

   adjacency_matrix_store #(
      .MAX_VERTICES (NV)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // gap length: mostly none or short, a few long
   function automatic int unsigned draw_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one request word and wait until it is taken
   task automatic send_req(input logic [1:0] kind, input vertex_type a, input vertex_type b);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, a, b);
   endtask

   // let the block drain, then write the vertex count
   task automatic write_count(input logic [6:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_count(value);
   endtask

   // mostly in-range vertices, some anywhere in the field
   function automatic vertex_type pick_vertex();
      if (sb.vertex_limit == 0 || $urandom_range(0, 9) == 0)
         return VTX_W'($urandom_range(0, NV - 1));
      return VTX_W'($urandom_range(0, sb.vertex_limit - 1));
   endfunction

   // random request mix; ignored kinds do not count toward n_items
   task automatic random_phase(input int unsigned n_items);
      int unsigned done_items;
      int unsigned r;
      logic [1:0]  kind;
      done_items = 0;
      while (done_items < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 40)      kind = KIND_ADD;
         else if (r < 65) kind = KIND_QUERY;
         else if (r < 90) kind = KIND_LIST;
         else             kind = KIND_NONE;
         send_req(kind, pick_vertex(), pick_vertex());
         if (kind != KIND_NONE) done_items++;
      end
   endtask

   // response side: check accepted words, stall at random
   initial begin : rsp_side
      int unsigned hold;
      int unsigned gap;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast);
         if (!pressure_done && sb.words_seen >= 30) begin
            hold          = HOLD_OFF;
            pressure_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            gap = draw_gap();
            if (gap == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               hold = gap - 1;
            end
         end
      end
   end

   // watchdog: too long without any word moving on either stream
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // main sequence
   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset count of 64
      send_req(KIND_LIST,  6'd10, 6'd0);    // no neighbors
      send_req(KIND_QUERY, 6'd0,  6'd63);
      send_req(KIND_ADD,   6'd0,  6'd63);
      send_req(KIND_ADD,   6'd63, 6'd0);    // repeated edge
      send_req(KIND_QUERY, 6'd63, 6'd0);
      send_req(KIND_ADD,   6'd5,  6'd5);    // self loop
      send_req(KIND_LIST,  6'd5,  6'd0);
      send_req(KIND_ADD,   6'd3,  6'd7);
      send_req(KIND_ADD,   6'd3,  6'd62);
      send_req(KIND_LIST,  6'd3,  6'd63);
      send_req(KIND_LIST,  6'd63, 6'd0);
      send_req(KIND_NONE,  6'd21, 6'd42);   // unused kind
      send_req(KIND_ADD,   6'd63, 6'd63);
      send_req(KIND_LIST,  6'd63, 6'd63);

      // shrunk count: stored edges beyond it are hidden
      write_count(7'd4);
      send_req(KIND_ADD,   6'd1,  6'd5);
      send_req(KIND_QUERY, 6'd4,  6'd0);
      send_req(KIND_LIST,  6'd4,  6'd0);
      send_req(KIND_LIST,  6'd3,  6'd0);
      send_req(KIND_LIST,  6'd0,  6'd0);
      send_req(KIND_ADD,   6'd0,  6'd3);
      send_req(KIND_LIST,  6'd3,  6'd0);

      // zero count: everything out of range
      write_count(7'd0);
      send_req(KIND_LIST,  6'd0,  6'd0);

      // count above the matrix size
      write_count(7'd127);
      send_req(KIND_LIST,  6'd0,  6'd0);

      // single vertex
      write_count(7'd1);
      send_req(KIND_ADD,   6'd0,  6'd0);
      send_req(KIND_QUERY, 6'd0,  6'd1);
      send_req(KIND_LIST,  6'd0,  6'd0);

      // random phases over several counts
      write_count(7'd64);
      random_phase(15);
      write_count(7'd127);
      no_idle = 1'b1;
      random_phase(15);
      write_count(7'd1);
      no_idle = 1'b0;
      random_phase(10);
      write_count(7'd0);
      random_phase(8);
      write_count(7'($urandom_range(2, 63)));
      random_phase(20);
      write_count(7'($urandom_range(2, 16)));
      no_idle = 1'b1;
      random_phase(15);
      write_count(7'd64);
      no_idle = 1'b0;
      random_phase(27);

      // drain and let any stray word show up
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d requests (%0d neighbor lists, %0d out of range), %0d response words",
               sb.requests_seen, sb.lists_seen, sb.ranges_seen, sb.words_seen);
      $display("vertex counts 0, 1, 64, 127 and random ones, with one long response hold-off");
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
